FILE: rtl/ttw_pkg.sv
// Package for the text-to-tile-map writer.
// Holds codes, screen constants, the controller state type and the
// command and status structs shared by the controller and the datapath.
package ttw_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] SCREEN_COLUMNS = 8'd48;
  localparam logic [7:0] LAST_ROW       = 8'd27;
  localparam int         TAB_STOP_LOG2  = 2;
  localparam int         MAP_ROW_SHIFT  = 6;
  localparam logic [3:0] FONT_MAX       = 4'd8;

  localparam logic [7:0] CHAR_END     = 8'd0;
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_CR      = 8'd13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FONT_WIDTH      = 3'd0,
    CFG_FONT_HEIGHT     = 3'd1,
    CFG_GLYPHS_PER_ROW  = 3'd2,
    CFG_FIRST_CHAR_CODE = 3'd3,
    CFG_CHARSET_BASE    = 3'd4,
    CFG_PALETTE_SEL     = 3'd5,
    CFG_ADVANCE_MODE    = 3'd6,
    CFG_MAP_BASE        = 3'd7
  } ttw_cfg_e;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECODE = 7'b0000010,
    ST_DIVIDE = 7'b0000100,
    ST_MUL1   = 7'b0001000,
    ST_MUL2   = 7'b0010000,
    ST_BASE   = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } ttw_state_e;

  typedef struct packed {
    logic accept;
    logic stop;
    logic tab;
    logic newline;
    logic start_glyph;
    logic div_start;
    logic mul1;
    logic mul2;
    logic base;
    logic emit;
    logic advance;
  } ttw_cmd_t;

  typedef struct packed {
    logic stopped;
    logic halt;
    logic is_cr;
    logic is_tab;
    logic is_newline;
    logic zero_size;
    logic need_div;
    logic div_done;
    logic out_free;
    logic last_tile;
  } ttw_status_t;

  function automatic logic [7:0] ttw_move(input logic [7:0] pos, input logic [3:0] amt,
                                          input logic dec);
    logic [7:0] ext;
    ext = {4'b0000, amt};
    return dec ? (pos - ext) : (pos + ext);
  endfunction

  function automatic logic [3:0] ttw_eff_size(input logic [3:0] v);
    return (v > FONT_MAX) ? FONT_MAX : v;
  endfunction

endpackage

FILE: rtl/ttw_div.sv
// Remainder unit for the glyph row term, two quotient bits per cycle.
// 8-bit dividend, 7-bit nonzero divisor; does not use ttw_pkg.
module ttw_div (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] dividend_i,
  input  logic [6:0] divisor_i,
  output logic       done_o,
  output logic [6:0] rem_o
);

  logic       busy_q, busy_d;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] dv_q, dv_d;
  logic [6:0] rem_q, rem_d;
  logic [6:0] r1;

  function automatic logic [6:0] div_step(input logic [6:0] r, input logic b,
                                          input logic [6:0] d);
    logic [7:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[6:0];
  endfunction

  assign done_o = busy_q && (cnt_q == 2'd3);
  assign rem_o  = rem_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dv_d   = dv_q;
    rem_d  = rem_q;
    r1     = div_step(rem_q, dv_q[7], divisor_i);
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 2'd0;
      dv_d   = dividend_i;
      rem_d  = 7'd0;
    end else if (busy_q) begin
      rem_d = div_step(r1, dv_q[6], divisor_i);
      dv_d  = {dv_q[5:0], 2'b00};
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q  <= dv_d;
    rem_q <= rem_d;
  end

endmodule

FILE: rtl/ttw_datapath.sv
// Datapath: config registers, cursor state, tile and address generation,
// output word register. Depends on ttw_pkg and ttw_div.
module ttw_datapath
  import ttw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ttw_cmd_t              cmd_i,
  output ttw_status_t           status_o,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  cfg_ready_o,
  input  logic [7:0]            char_code_i,
  input  logic                  string_start_i,
  input  logic [7:0]            start_col_i,
  input  logic [7:0]            start_row_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [15:0]           map_address_o,
  output logic [15:0]           tile_word_o,
  output logic                  last_write_o
);

  logic [3:0]  font_width_q, font_height_q;
  logic [6:0]  glyphs_per_row_q;
  logic [7:0]  first_char_q;
  logic [10:0] charset_base_q;
  logic [1:0]  palette_q, mode_q;
  logic [15:0] map_base_q;

  logic [7:0]  col_q, col_d, row_q, row_d, line_start_q, line_start_d;
  logic        stopped_q, stopped_d;
  logic        out_valid_q, out_valid_d;

  logic [7:0]  ch_q;
  logic [7:0]  glyph_q;
  logic [11:0] qgw_q;
  logic [15:0] rowterm_q;
  logic [10:0] stride_q;
  logic [15:0] col_tile_q, tile_q, col_addr_q, addr_q;
  logic [2:0]  gx_q, gy_q;
  logic [15:0] out_addr_q, out_tile_q;
  logic        out_last_q;

  logic [3:0]  w_eff, h_eff, w_m1, h_m1;
  logic [7:0]  glyph_d, qg;
  logic [6:0]  div_rem;
  logic        div_done;
  logic [11:0] glyph_w, qgw_d;
  logic [15:0] rowterm_d, tile_base, pos, col_addr_d;
  logic [10:0] stride_d;
  logic [7:0]  tab_col_base, tab_row_base;
  logic [11:0] tab_col_prod, tab_row_prod;
  logic [7:0]  adv_col, adv_row;
  logic        new_column, last_tile;

  assign w_eff = ttw_eff_size(font_width_q);
  assign h_eff = ttw_eff_size(font_height_q);
  assign w_m1  = w_eff - 4'd1;
  assign h_m1  = h_eff - 4'd1;

  assign glyph_d = ch_q - first_char_q;

  ttw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (glyph_d),
    .divisor_i  (glyphs_per_row_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign qg        = glyph_q - {1'b0, div_rem};
  assign qgw_d     = {4'b0000, qg} * {8'b0, w_eff};
  assign rowterm_d = {4'b0000, qgw_q} * {12'b0, h_m1};
  assign glyph_w   = {4'b0000, glyph_q} * {8'b0, w_eff};
  assign tile_base = {5'b0, charset_base_q} + {4'b0, glyph_w} + rowterm_q;
  assign stride_d  = {4'b0000, glyphs_per_row_q} * {7'b0, w_eff};
  assign pos       = {2'b00, row_q, {MAP_ROW_SHIFT{1'b0}}} + {8'b0, col_q};
  assign col_addr_d = map_base_q + pos;

  assign new_column = (gy_q == h_m1[2:0]);
  assign last_tile  = (gx_q == w_m1[2:0]) && new_column;

  // tab stops
  assign tab_col_base = ((col_q >> TAB_STOP_LOG2) + 8'd1) << TAB_STOP_LOG2;
  assign tab_row_base = ((row_q >> TAB_STOP_LOG2) + 8'd1) << TAB_STOP_LOG2;
  assign tab_col_prod = {4'b0000, tab_col_base} * {8'b0, w_eff};
  assign tab_row_prod = {4'b0000, tab_row_base} * {8'b0, h_eff};

  always_comb begin
    if (mode_q[0]) begin
      adv_row = ttw_move(row_q, h_eff, mode_q[1]);
      adv_col = col_q;
    end else begin
      adv_row = row_q;
      adv_col = ttw_move(col_q, w_eff, mode_q[1]);
    end
  end

  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    line_start_d = line_start_q;
    stopped_d    = stopped_q;
    if (cmd_i.accept && string_start_i) begin
      col_d        = start_col_i;
      line_start_d = start_col_i;
      row_d        = start_row_i;
      stopped_d    = 1'b0;
    end
    if (cmd_i.stop) begin
      stopped_d = 1'b1;
    end
    if (cmd_i.tab) begin
      if (mode_q[0]) begin
        row_d = tab_row_prod[7:0];
      end else begin
        col_d = tab_col_prod[7:0];
      end
    end
    if (cmd_i.newline) begin
      row_d = ttw_move(row_q, h_eff, mode_q[1]);
      col_d = line_start_q;
    end
    if (cmd_i.advance) begin
      if (adv_col >= SCREEN_COLUMNS) begin
        row_d = ttw_move(adv_row, h_eff, mode_q[1]);
        col_d = line_start_q;
      end else begin
        row_d = adv_row;
        col_d = adv_col;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_width_q     <= 4'd1;
      font_height_q    <= 4'd1;
      glyphs_per_row_q <= 7'd32;
      first_char_q     <= 8'd32;
      charset_base_q   <= 11'd0;
      palette_q        <= 2'd0;
      mode_q           <= 2'd0;
      map_base_q       <= 16'd0;
      col_q            <= 8'd0;
      row_q            <= 8'd0;
      line_start_q     <= 8'd0;
      stopped_q        <= 1'b1;
      out_valid_q      <= 1'b0;
    end else begin
      col_q        <= col_d;
      row_q        <= row_d;
      line_start_q <= line_start_d;
      stopped_q    <= stopped_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_FONT_WIDTH:      font_width_q     <= cfg_data_i[3:0];
          CFG_FONT_HEIGHT:     font_height_q    <= cfg_data_i[3:0];
          CFG_GLYPHS_PER_ROW:  glyphs_per_row_q <= cfg_data_i[6:0];
          CFG_FIRST_CHAR_CODE: first_char_q     <= cfg_data_i[7:0];
          CFG_CHARSET_BASE:    charset_base_q   <= cfg_data_i[10:0];
          CFG_PALETTE_SEL:     palette_q        <= cfg_data_i[1:0];
          CFG_ADVANCE_MODE:    mode_q           <= cfg_data_i[1:0];
          CFG_MAP_BASE:        map_base_q       <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ch_q <= char_code_i;
    end
    if (cmd_i.start_glyph) begin
      glyph_q   <= glyph_d;
      rowterm_q <= 16'd0;
    end
    if (cmd_i.mul1) begin
      qgw_q <= qgw_d;
    end
    if (cmd_i.mul2) begin
      rowterm_q <= rowterm_d;
    end
    if (cmd_i.base) begin
      col_tile_q <= tile_base;
      tile_q     <= tile_base;
      stride_q   <= stride_d;
      col_addr_q <= col_addr_d;
      addr_q     <= col_addr_d;
      gx_q       <= 3'd0;
      gy_q       <= 3'd0;
    end
    if (cmd_i.emit) begin
      out_addr_q <= addr_q;
      out_tile_q <= {tile_q[15:14] | palette_q, tile_q[13:0]};
      out_last_q <= last_tile;
      if (new_column) begin
        gy_q       <= 3'd0;
        gx_q       <= gx_q + 3'd1;
        col_addr_q <= col_addr_q + 16'd1;
        addr_q     <= col_addr_q + 16'd1;
        col_tile_q <= col_tile_q + 16'd1;
        tile_q     <= col_tile_q + 16'd1;
      end else begin
        gy_q   <= gy_q + 3'd1;
        addr_q <= addr_q + (16'd1 << MAP_ROW_SHIFT);
        tile_q <= tile_q + {5'b0, stride_q};
      end
    end
  end

  assign status_o.stopped    = stopped_q;
  assign status_o.halt       = (ch_q == CHAR_END) || (col_q >= SCREEN_COLUMNS) ||
                               (row_q > LAST_ROW);
  assign status_o.is_cr      = (ch_q == CHAR_CR);
  assign status_o.is_tab     = (ch_q == CHAR_TAB);
  assign status_o.is_newline = (ch_q == CHAR_NEWLINE);
  assign status_o.zero_size  = (w_eff == 4'd0) || (h_eff == 4'd0);
  assign status_o.need_div   = (glyphs_per_row_q != 7'd0) && (h_eff > 4'd1);
  assign status_o.div_done   = div_done;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.last_tile  = last_tile;

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign map_address_o = out_addr_q;
  assign tile_word_o   = out_tile_q;
  assign last_write_o  = out_last_q;

endmodule

FILE: rtl/ttw_ctrl.sv
// Controller state machine: sequences decode, remainder, multiplies and
// the tile write loop. Depends on ttw_pkg.
module ttw_ctrl
  import ttw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ttw_status_t status_i,
  output ttw_cmd_t    cmd_o
);

  ttw_state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_IDLE;
        if (status_i.stopped || status_i.is_cr && !status_i.halt) begin
        end else if (status_i.halt) begin
          cmd_o.stop = 1'b1;
        end else if (status_i.is_tab) begin
          cmd_o.tab = 1'b1;
        end else if (status_i.is_newline) begin
          cmd_o.newline = 1'b1;
        end else if (status_i.zero_size) begin
          cmd_o.advance = 1'b1;
        end else begin
          cmd_o.start_glyph = 1'b1;
          if (status_i.need_div) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIVIDE;
          end else begin
            state_d = ST_BASE;
          end
        end
      end
      ST_DIVIDE: begin
        if (status_i.div_done) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_BASE;
      end
      ST_BASE: begin
        cmd_o.base = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_tile) begin
            cmd_o.advance = 1'b1;
            state_d       = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/text_to_tilemap_writer_core.sv
// Top level of the text-to-tile-map writer.
// Joins ttw_ctrl and ttw_datapath; depends on ttw_pkg.
//
// One character word is taken at a time. A control code, an ignored code,
// a character of a stopped string or the code that ends a string goes
// from decode straight back to idle, as does a printable character in a
// zero-size font. A printable character with a w x h font gives w*h map
// writes, one per cycle unless the output stalls. When the font is one
// tile high or glyphs_per_row is zero, the writes follow decode and base
// directly; otherwise the glyph row term first waits on the remainder
// unit and two registered multiplies. The next character is accepted
// while the previous one's last write still sits in the output register.
module text_to_tilemap_writer_core
  import ttw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            char_code_i,
  input  logic                  string_start_i,
  input  logic [7:0]            start_col_i,
  input  logic [7:0]            start_row_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [15:0]           map_address_o,
  output logic [15:0]           tile_word_o,
  output logic                  last_write_o
);

  ttw_cmd_t    cmd;
  ttw_status_t status;

  ttw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ttw_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_ready_o    (cfg_ready_o),
    .char_code_i    (char_code_i),
    .string_start_i (string_start_i),
    .start_col_i    (start_col_i),
    .start_row_i    (start_row_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .map_address_o  (map_address_o),
    .tile_word_o    (tile_word_o),
    .last_write_o   (last_write_o)
  );

endmodule

FILE: rtl/ttw_checker.sv
// Port-level checker for text_to_tilemap_writer_core, bound to the top.
// Depends on ttw_pkg.
module ttw_checker
  import ttw_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [7:0]            char_code_i,
  input logic                  string_start_i,
  input logic [7:0]            start_col_i,
  input logic [7:0]            start_row_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [15:0]           map_address_o,
  input logic [15:0]           tile_word_o,
  input logic                  last_write_o
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_word_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(map_address_o) && $stable(tile_word_o) &&
                                   $stable(last_write_o))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on back-to-back cycles");

  a_no_accept_mid_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_write_o |-> in_stall_o)
    else $error("input ready before a character's writes are done");

endmodule

bind text_to_tilemap_writer_core ttw_checker u_ttw_checker (.*);
